// ===== hw/rtl/dacr_pkg.sv =====
// Shared types and fixed constants for the DAC ramp generator.
// No dependencies; imported by every module of the block.
package dacr_pkg;

    localparam int IN_W        = 16;   // request width
    localparam int STEPS_W     = 6;    // ramp length register width
    localparam int ZERO_W      = 12;   // zero code register width
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int SMALL_CHANGE = 20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_CODE  = 2'd2;

    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic load;
        logic advance;
    } t_ramp_ctrl;

endpackage

// ===== hw/rtl/dacr_div.sv =====
// Restoring divider, one quotient bit per cycle: ramp distance by ramp length.
// Depends on dacr_pkg.
module dacr_div #(
    parameter int DAC_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dacr_pkg::t_div_ctrl            i_ctrl,
    input  logic [DAC_BITS-1:0]            i_dividend,
    input  logic [dacr_pkg::STEPS_W-1:0]   i_divisor,
    output dacr_pkg::t_div_stat            o_stat,
    output logic [DAC_BITS-1:0]            o_quo,
    output logic [dacr_pkg::STEPS_W-1:0]   o_rem
);
    import dacr_pkg::*;

    localparam int CNT_W = $clog2(DAC_BITS + 1);

    logic [DAC_BITS-1:0] r_quo;
    logic [STEPS_W-1:0]  r_rem;
    logic [STEPS_W-1:0]  r_dvs;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [STEPS_W:0]    shifted;
    logic [STEPS_W:0]    diff;
    logic                fits;

    assign shifted = {r_rem, r_quo[DAC_BITS-1]};
    assign fits    = shifted >= {1'b0, r_dvs};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DAC_BITS-2:0], fits};
            r_rem <= fits ? diff[STEPS_W-1:0] : shifted[STEPS_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule

// ===== hw/rtl/dacr_ramp.sv =====
// Error-accumulator interpolator: one ramp sample per advance, saturated output.
// Depends on dacr_pkg.
module dacr_ramp #(
    parameter int DAC_BITS = 12
) (
    input  logic                  i_clk,
    input  dacr_pkg::t_ramp_ctrl  i_ctrl,
    input  logic [DAC_BITS-1:0]   i_origin,
    input  logic                  i_dir_neg,
    input  logic [DAC_BITS-1:0]   i_carry_mag,
    input  logic [DAC_BITS-1:0]   i_fixed_mag,
    input  logic [DAC_BITS-1:0]   i_den,
    input  logic [DAC_BITS-1:0]   i_num,
    input  logic [DAC_BITS-1:0]   i_add,
    output logic [DAC_BITS-1:0]   o_sample
);
    import dacr_pkg::*;

    localparam int NW = DAC_BITS + 1;
    localparam int YW = DAC_BITS + 3;
    localparam logic [DAC_BITS-1:0] DAC_MAX = {DAC_BITS{1'b1}};

    logic signed [YW-1:0] r_y;
    logic [NW-1:0]        r_num;
    logic [NW-1:0]        r_den;
    logic [NW-1:0]        r_add;
    logic [NW-1:0]        r_carry;
    logic [NW-1:0]        r_fixed;
    logic                 r_neg;

    logic [NW-1:0]        sum;
    logic                 wrap;
    logic [NW-1:0]        delta;
    logic signed [YW-1:0] delta_s;

    assign sum     = r_num + r_add;
    assign wrap    = sum >= r_den;
    assign delta   = (wrap ? r_carry : '0) + r_fixed;
    assign delta_s = signed'(YW'(delta));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_y     <= signed'(YW'(i_origin));
            r_num   <= NW'(i_num);
            r_den   <= NW'(i_den);
            r_add   <= NW'(i_add);
            r_carry <= NW'(i_carry_mag);
            r_fixed <= NW'(i_fixed_mag);
            r_neg   <= i_dir_neg;
        end else if (i_ctrl.advance) begin
            r_num <= wrap ? sum - r_den : sum;
            r_y   <= r_neg ? r_y - delta_s : r_y + delta_s;
        end
    end

    // clip to the DAC range; the running value itself is kept unclipped
    always_comb begin
        if (r_y[YW-1]) begin
            o_sample = '0;
        end else if (r_y > signed'(YW'(DAC_MAX))) begin
            o_sample = DAC_MAX;
        end else begin
            o_sample = r_y[DAC_BITS-1:0];
        end
    end

endmodule

// ===== hw/rtl/dac_ramp_generator.sv =====
// DAC ramp generator. Each request takes one input beat; a repeat of the last
// target gives no beat, a direct write or a change under 20 codes gives one beat,
// and a ramp gives ramp_steps (0 counts as 1) interpolated beats plus the target
// (last = 1). A ramp passes through the accept, the bit-serial divider and its done
// flag, the setup state and then one output beat per cycle while the output is not
// stalled (n + 1 beats); input stays stalled meanwhile.
module dac_ramp_generator #(
    parameter int MAX_RAMP_STEPS = 63,
    parameter int DAC_BITS       = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [dacr_pkg::IN_W-1:0]         i_target_code,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [DAC_BITS-1:0]               o_dac_code,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dacr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dacr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dacr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_SETUP = 2'd2;
    localparam logic [1:0] ST_RAMP  = 2'd3;

    localparam logic [DAC_BITS-1:0] DAC_MAX = {DAC_BITS{1'b1}};

    logic [1:0]          r_state, n_state;
    logic                r_mode;
    logic [STEPS_W-1:0]  r_steps;
    logic [ZERO_W-1:0]   r_zero;
    logic [DAC_BITS-1:0] r_last_tgt;
    logic [DAC_BITS-1:0] r_origin;
    logic [DAC_BITS-1:0] r_target;
    logic [DAC_BITS-1:0] r_start;
    logic [DAC_BITS-1:0] r_dist;
    logic                r_dir_neg;
    logic [STEPS_W-1:0]  r_n;
    logic [STEPS_W-1:0]  r_cnt;
    logic                r_final;
    logic                r_out_valid;
    logic [DAC_BITS-1:0] r_out_code;
    logic                r_out_last;

    logic                out_free;
    logic                in_acc;
    logic [IN_W-1:0]     last_ext;
    logic [IN_W-1:0]     zero_ext;
    logic                repeat_req;
    logic [DAC_BITS-1:0] clamped;
    logic [DAC_BITS-1:0] req;
    logic [DAC_BITS:0]   diff;
    logic [DAC_BITS-1:0] mag;
    logic                single;
    logic [STEPS_W-1:0]  n_eff;

    t_div_ctrl           div_ctrl;
    t_div_stat           div_stat;
    logic [DAC_BITS-1:0] quo;
    logic [STEPS_W-1:0]  rem;

    t_ramp_ctrl          ramp_ctrl;
    logic                short_ramp;
    logic [DAC_BITS-1:0] carry_mag;
    logic [DAC_BITS-1:0] fixed_mag;
    logic [DAC_BITS-1:0] den;
    logic [DAC_BITS-1:0] add;
    logic [DAC_BITS-1:0] sample;

    assign out_free    = !r_out_valid || !i_stall;
    assign o_stall     = (r_state != ST_IDLE) || !out_free;
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // request decode
    assign last_ext   = IN_W'(r_last_tgt);
    assign zero_ext   = IN_W'(r_zero);
    assign repeat_req = i_target_code == last_ext;
    assign clamped    = (i_target_code > IN_W'(DAC_MAX)) ? DAC_MAX
                                                         : DAC_BITS'(i_target_code);
    assign req        = (r_mode && i_target_code == '0) ? DAC_BITS'(zero_ext) : clamped;
    assign diff       = {1'b0, req} - {1'b0, r_origin};
    assign mag        = diff[DAC_BITS] ? DAC_BITS'(-diff) : diff[DAC_BITS-1:0];
    assign single     = !r_mode || (mag < DAC_BITS'(SMALL_CHANGE));

    always_comb begin
        n_eff = (r_steps == '0) ? STEPS_W'(1) : r_steps;
        if (n_eff > STEPS_W'(MAX_RAMP_STEPS)) begin
            n_eff = STEPS_W'(MAX_RAMP_STEPS);
        end
    end

    assign div_ctrl.start = in_acc && !repeat_req && !single;

    dacr_div #(.DAC_BITS(DAC_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_dividend (mag),
        .i_divisor  (n_eff),
        .o_stat     (div_stat),
        .o_quo      (quo),
        .o_rem      (rem)
    );

    // ramp setup from quotient and remainder
    assign short_ramp = DAC_BITS'(r_n) >= r_dist;
    always_comb begin
        if (short_ramp) begin
            carry_mag = DAC_BITS'(1);
            fixed_mag = '0;
            den       = DAC_BITS'(r_n);
            add       = r_dist;
        end else begin
            carry_mag = quo;
            fixed_mag = quo;
            den       = (quo > DAC_BITS'(1)) ? r_dist : DAC_BITS'(r_n);
            add       = DAC_BITS'(rem);
        end
    end

    assign ramp_ctrl.load    = r_state == ST_SETUP;
    assign ramp_ctrl.advance = (r_state == ST_RAMP) && !r_final && out_free;

    dacr_ramp #(.DAC_BITS(DAC_BITS)) u_ramp (
        .i_clk       (i_clk),
        .i_ctrl      (ramp_ctrl),
        .i_origin    (r_start),
        .i_dir_neg   (r_dir_neg),
        .i_carry_mag (carry_mag),
        .i_fixed_mag (fixed_mag),
        .i_den       (den),
        .i_num       (den >> 1),
        .i_add       (add),
        .o_sample    (sample)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (div_ctrl.start) n_state = ST_DIV;
            ST_DIV:   if (div_stat.done) n_state = ST_SETUP;
            ST_SETUP: n_state = ST_RAMP;
            ST_RAMP:  if (r_final && out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= 1'b0;
            r_steps     <= STEPS_W'(10);
            r_zero      <= '0;
            r_last_tgt  <= '0;
            r_origin    <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_final     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_RAMP_MODE:  r_mode  <= i_cfg_data[0];
                    REG_RAMP_STEPS: r_steps <= i_cfg_data[STEPS_W-1:0];
                    REG_ZERO_CODE:  r_zero  <= i_cfg_data[ZERO_W-1:0];
                    default:        ;
                endcase
            end
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc && !repeat_req) begin
                r_last_tgt <= req;
                r_origin   <= req;
                if (single) begin
                    r_out_valid <= 1'b1;
                end
            end
            if (r_state == ST_SETUP) begin
                r_cnt   <= '0;
                r_final <= 1'b0;
            end
            if (r_state == ST_RAMP && out_free) begin
                r_out_valid <= 1'b1;
                if (!r_final) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == r_n - 1'b1) begin
                        r_final <= 1'b1;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc && !repeat_req) begin
            r_target  <= req;
            r_start   <= r_origin;
            r_dist    <= mag;
            r_dir_neg <= diff[DAC_BITS];
            r_n       <= n_eff;
            if (single) begin
                r_out_code <= req;
                r_out_last <= 1'b1;
            end
        end
        if (r_state == ST_RAMP && out_free) begin
            r_out_code <= r_final ? r_target : sample;
            r_out_last <= r_final;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_dac_code = r_out_code;
    assign o_last     = r_out_last;

`ifndef ASSERT_OFF
    // a beat that is not the last one only comes from a ramp in progress
    a_mid_beat_in_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_state == ST_RAMP))
        else $error("non-final beat outside a ramp");

    // the divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == ST_DIV))
        else $error("divider done outside divide state");

    // the sample count never runs past the ramp length
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RAMP) |-> (r_cnt <= r_n))
        else $error("ramp sample count overran");
`endif

endmodule
